/* src/mrrl_pkg.sv */
// Shared types and constants for the monitor request/response link.
// Used by mrrl_ctrl, mrrl_dpath and monitor_request_response_link.
package mrrl_pkg;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_RX    = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_PAY  = 2'd1,
        KIND_OK   = 2'd2,
        KIND_FAIL = 2'd3
    } kind_t;

    localparam logic [7:0]  LEN_MARK  = 8'h10;
    localparam logic [7:0]  PAD_BYTE  = 8'h00;
    localparam logic [4:0]  SUM_LEN   = 5'd18;
    localparam logic [15:0] TICK_MAX  = 16'hFFFF;
    localparam logic [3:0]  REQ_LAST  = 4'd2;
    localparam logic [3:0]  PAY_LAST  = 4'd15;

    localparam logic        ADDR_RETRY_LIMIT   = 1'b0;
    localparam logic        ADDR_TIMEOUT_TICKS = 1'b1;

    typedef struct packed {
        logic  capture;
        logic  start;
        logic  rx;
        logic  tick;
        logic  retry;
        logic  finish;
        logic  cnt_clr;
        logic  load;
        kind_t kind;
    } mrrl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  busy;
        logic  frame_done;
        logic  frame_bad;
        logic  timed_out;
        logic  can_retry;
        logic  out_free;
        logic  req_end;
        logic  pay_end;
    } mrrl_stat_t;

endpackage

/* src/mrrl_dpath.sv */
// Datapath: link state, frame checking, payload store and result register.
// Depends on mrrl_pkg; driven by commands from mrrl_ctrl.
module mrrl_dpath (
    input  logic              aclk,
    input  logic              aresetn,
    input  mrrl_pkg::mrrl_cmd_t  cmd,
    output mrrl_pkg::mrrl_stat_t stat,
    input  logic [3:0]        retry_limit,
    input  logic [15:0]       timeout_ticks,
    input  logic [1:0]        in_mode,
    input  logic [7:0]        in_command,
    input  logic [7:0]        in_rx_byte,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [1:0]        m_kind,
    output logic [7:0]        m_value,
    output logic [3:0]        m_index,
    output logic              m_last
);
    import mrrl_pkg::*;

    logic [1:0]  mode_reg;
    logic [7:0]  cmd_in_reg;
    logic [7:0]  byte_in_reg;
    logic        busy_reg;
    logic [7:0]  act_cmd_reg;
    logic [4:0]  byte_cnt_reg;
    logic [7:0]  sum_reg;
    logic        ferr_reg;
    logic [3:0]  attempt_reg;
    logic [15:0] ticks_reg;
    logic [3:0]  emit_cnt_reg;
    logic [7:0]  store [16];

    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [7:0]  out_value_reg;
    logic [3:0]  out_index_reg;
    logic        out_last_reg;

    logic [3:0]  store_off;
    logic [15:0] ticks_next;
    logic        byte_err;

    assign store_off  = byte_cnt_reg[3:0] - 4'd2;
    assign ticks_next = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + 16'd1;
    assign byte_err   = ((byte_cnt_reg == 5'd0) && (byte_in_reg != act_cmd_reg))
                     || ((byte_cnt_reg == 5'd1) && (byte_in_reg != LEN_MARK))
                     || ((byte_cnt_reg == SUM_LEN) && (byte_in_reg != sum_reg));

    always_comb begin
        stat.mode       = mode_t'(mode_reg);
        stat.busy       = busy_reg;
        stat.frame_done = (byte_cnt_reg == SUM_LEN);
        stat.frame_bad  = ferr_reg | byte_err;
        stat.timed_out  = (ticks_next >= timeout_ticks);
        stat.can_retry  = (attempt_reg < retry_limit);
        stat.out_free   = !out_valid_reg || m_tready;
        stat.req_end    = (emit_cnt_reg == REQ_LAST);
        stat.pay_end    = (emit_cnt_reg == PAY_LAST);
    end

    // input capture and payload store
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg    <= in_mode;
            cmd_in_reg  <= in_command;
            byte_in_reg <= in_rx_byte;
        end
        if (cmd.rx && (byte_cnt_reg >= 5'd2) && (byte_cnt_reg < SUM_LEN)) begin
            store[store_off] <= byte_in_reg;
        end
    end

    // link state; a frame clear overrides the byte and tick updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            act_cmd_reg  <= 8'd0;
            byte_cnt_reg <= 5'd0;
            sum_reg      <= 8'd0;
            ferr_reg     <= 1'b0;
            attempt_reg  <= 4'd0;
            ticks_reg    <= 16'd0;
        end else begin
            if (cmd.rx) begin
                byte_cnt_reg <= byte_cnt_reg + 5'd1;
                if (byte_cnt_reg < SUM_LEN) begin
                    sum_reg <= sum_reg + byte_in_reg;
                end
                if (byte_err) begin
                    ferr_reg <= 1'b1;
                end
            end
            if (cmd.tick) begin
                ticks_reg <= ticks_next;
            end
            if (cmd.start) begin
                busy_reg    <= 1'b1;
                act_cmd_reg <= cmd_in_reg;
                attempt_reg <= 4'd0;
            end
            if (cmd.retry) begin
                attempt_reg <= attempt_reg + 4'd1;
            end
            if (cmd.finish) begin
                busy_reg <= 1'b0;
            end
            if (cmd.start || cmd.retry || cmd.finish) begin
                byte_cnt_reg <= 5'd0;
                sum_reg      <= 8'd0;
                ferr_reg     <= 1'b0;
                ticks_reg    <= 16'd0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            emit_cnt_reg  <= 4'd0;
        end else begin
            if (cmd.cnt_clr) begin
                emit_cnt_reg <= 4'd0;
            end else if (cmd.load) begin
                emit_cnt_reg <= emit_cnt_reg + 4'd1;
            end
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_kind_reg <= cmd.kind;
            case (cmd.kind)
                KIND_TX: begin
                    out_value_reg <= (emit_cnt_reg == 4'd1) ? PAD_BYTE : act_cmd_reg;
                    out_index_reg <= 4'd0;
                    out_last_reg  <= (emit_cnt_reg == REQ_LAST);
                end
                KIND_PAY: begin
                    out_value_reg <= store[emit_cnt_reg];
                    out_index_reg <= emit_cnt_reg;
                    out_last_reg  <= 1'b0;
                end
                default: begin
                    out_value_reg <= 8'd0;
                    out_index_reg <= 4'd0;
                    out_last_reg  <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_kind   = out_kind_reg;
    assign m_value  = out_value_reg;
    assign m_index  = out_index_reg;
    assign m_last   = out_last_reg;

endmodule

/* src/mrrl_ctrl.sv */
// Controller: sequences input evaluation, request transmit and reply results.
// Depends on mrrl_pkg; commands mrrl_dpath.
module mrrl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mrrl_pkg::mrrl_stat_t stat,
    output mrrl_pkg::mrrl_cmd_t  cmd
);
    import mrrl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_REQ,
        S_PAY,
        S_STAT
    } state_t;

    state_t state_reg, state_next;
    logic   fail_reg, fail_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fail_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fail_reg  <= fail_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        fail_next   = fail_reg;
        cmd         = '0;
        cmd.kind    = KIND_TX;
        case (state_reg)
            S_IDLE: begin
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = S_IDLE;
                case (stat.mode)
                    MODE_START: begin
                        if (!stat.busy) begin
                            cmd.start   = 1'b1;
                            cmd.cnt_clr = 1'b1;
                            state_next  = S_REQ;
                        end
                    end
                    MODE_RX: begin
                        if (stat.busy) begin
                            cmd.rx = 1'b1;
                            if (stat.frame_done) begin
                                if (!stat.frame_bad) begin
                                    cmd.finish  = 1'b1;
                                    cmd.cnt_clr = 1'b1;
                                    fail_next   = 1'b0;
                                    state_next  = S_PAY;
                                end else if (stat.can_retry) begin
                                    cmd.retry   = 1'b1;
                                    cmd.cnt_clr = 1'b1;
                                    state_next  = S_REQ;
                                end else begin
                                    cmd.finish = 1'b1;
                                    fail_next  = 1'b1;
                                    state_next = S_STAT;
                                end
                            end
                        end
                    end
                    MODE_TICK: begin
                        if (stat.busy) begin
                            cmd.tick = 1'b1;
                            if (stat.timed_out) begin
                                if (stat.can_retry) begin
                                    cmd.retry   = 1'b1;
                                    cmd.cnt_clr = 1'b1;
                                    state_next  = S_REQ;
                                end else begin
                                    cmd.finish = 1'b1;
                                    fail_next  = 1'b1;
                                    state_next = S_STAT;
                                end
                            end
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_REQ: begin
                cmd.kind = KIND_TX;
                if (stat.out_free) begin
                    cmd.load = 1'b1;
                    if (stat.req_end) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_PAY: begin
                cmd.kind = KIND_PAY;
                if (stat.out_free) begin
                    cmd.load = 1'b1;
                    if (stat.pay_end) begin
                        state_next = S_STAT;
                    end
                end
            end
            S_STAT: begin
                cmd.kind = fail_reg ? KIND_FAIL : KIND_OK;
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/monitor_request_response_link.sv */
// Request/response link to a motor controller. An input transaction is taken in S_IDLE
// and judged in S_EVAL; s_tready is high only in S_IDLE, so a new transaction waits
// until the results of the previous one are loaded. A request (start or retry) emits the
// request bytes, a good reply its payload and an OK status, and a failure a FAIL status,
// all through the single result register in the controller's emit sequence. Configuration
// sits on an APB port: retry limit at 0x0 (reset 2), timeout_ticks at 0x4 (reset 100).
// Top level: APB registers, mrrl_ctrl and mrrl_dpath; depends on mrrl_pkg.
module monitor_request_response_link (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] command, [15:8] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] value, [11:8] payload_index, [15:12] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);
    import mrrl_pkg::*;

    logic [3:0]  retry_limit_reg;
    logic [15:0] timeout_ticks_reg;
    logic        cfg_wr;

    mrrl_cmd_t   cmd;
    mrrl_stat_t  stat;
    logic [7:0]  out_value;
    logic [3:0]  out_index;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_limit_reg   <= 4'd2;
            timeout_ticks_reg <= 16'd100;
        end else if (cfg_wr) begin
            if (paddr[2] == ADDR_RETRY_LIMIT) begin
                retry_limit_reg <= pwdata[3:0];
            end else begin
                timeout_ticks_reg <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            ADDR_RETRY_LIMIT:   prdata = {28'd0, retry_limit_reg};
            ADDR_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks_reg};
            default:            prdata = 32'd0;
        endcase
    end

    mrrl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mrrl_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .retry_limit   (retry_limit_reg),
        .timeout_ticks (timeout_ticks_reg),
        .in_mode       (s_tuser),
        .in_command    (s_tdata[7:0]),
        .in_rx_byte    (s_tdata[15:8]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_kind        (m_tuser),
        .m_value       (out_value),
        .m_index       (out_index),
        .m_last        (m_tlast)
    );

    assign m_tdata = {4'd0, out_index, out_value};

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while previous transaction still in evaluation");

    a_status_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_OK || m_tuser == KIND_FAIL))
        |-> (m_tdata == 16'd0 && m_tlast))
        else $error("status result with non-zero data or without last");

    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr && paddr[2] == ADDR_TIMEOUT_TICKS)
        |=> (timeout_ticks_reg == $past(pwdata[15:0])))
        else $error("timeout_ticks register not updated by write");

endmodule
